@@ rtl/bmie_pkg.sv @@
// Package for the byte memory instruction executor.
// Holds field widths, opcodes and the controller/datapath command and status types.
// No dependencies.
package bmie_pkg;

	localparam int DATA_W   = 8;
	localparam int ACTION_W = 5;
	localparam int INDEX_W  = 16;
	localparam int INVAL_W  = 16;

	localparam logic [ACTION_W-1:0] OP_NOP    = 5'd0;
	localparam logic [ACTION_W-1:0] OP_COPY   = 5'd1;
	localparam logic [ACTION_W-1:0] OP_MOVE   = 5'd2;
	localparam logic [ACTION_W-1:0] OP_ADD    = 5'd3;
	localparam logic [ACTION_W-1:0] OP_SUB    = 5'd4;
	localparam logic [ACTION_W-1:0] OP_MUL    = 5'd5;
	localparam logic [ACTION_W-1:0] OP_DIV    = 5'd6;
	localparam logic [ACTION_W-1:0] OP_MOD    = 5'd7;
	localparam logic [ACTION_W-1:0] OP_AND    = 5'd8;
	localparam logic [ACTION_W-1:0] OP_OR     = 5'd9;
	localparam logic [ACTION_W-1:0] OP_NOT    = 5'd10;
	localparam logic [ACTION_W-1:0] OP_XOR    = 5'd11;
	localparam logic [ACTION_W-1:0] OP_SHR    = 5'd12;
	localparam logic [ACTION_W-1:0] OP_SHL    = 5'd13;
	localparam logic [ACTION_W-1:0] OP_JUMP   = 5'd14;
	localparam logic [ACTION_W-1:0] OP_EQ     = 5'd15;
	localparam logic [ACTION_W-1:0] OP_GT     = 5'd16;
	localparam logic [ACTION_W-1:0] OP_LT     = 5'd17;
	localparam logic [ACTION_W-1:0] OP_SKIPIF = 5'd18;
	localparam logic [ACTION_W-1:0] OP_HALT   = 5'd19;
	localparam logic [ACTION_W-1:0] OP_OUT    = 5'd20;
	localparam logic [ACTION_W-1:0] OP_IN     = 5'd21;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // take the input fields and read both operands
		logic div_start;  // load the serial divider
		logic commit;     // write memory, update the line index, load the result
	} bmie_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_needed; // a divide or modulo with a nonzero divisor is pending and the block is not halted
		logic div_busy;   // the serial divider is still stepping
	} bmie_sts_t;

endpackage

@@ rtl/byte_memory_instruction_executor_core.sv @@
// Top level of the byte memory instruction executor.
// Depends on bmie_pkg, bmie_ctrl, bmie_dpath (which holds bmie_div).
//
// The block executes one decoded instruction per input transfer on a private
// memory of signed bytes and answers each with exactly one result transfer: the
// next program line, an output byte with its flag, the halted and fault flags.
// Both channels use valid/stall: a transfer happens on a rising edge where
// valid is high and stall is low. The input stall is high while an
// instruction is being executed; it drops as soon as the result is loaded
// into the output register, so the next instruction can be taken while that
// result still waits for the receiver.
// Both operands are read from the memory at the input transfer edge. The result
// is loaded when the controller commits; divide and modulo with a nonzero divisor
// first go through a start step and eight serial divider steps of one quotient
// bit each, and the commit follows them.
// If the receiver stalls, the result register holds its contents and a
// second finished instruction waits inside the block without committing.
// Reset sets the program line to 1 and clears the halt flag; the memory
// content is undefined until written, so no clearing pass is needed.
module byte_memory_instruction_executor_core #(
	parameter int MEMORY_DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [bmie_pkg::ACTION_W-1:0]          action,
	input  logic [bmie_pkg::DATA_W-1:0]            addr_a,
	input  logic [bmie_pkg::DATA_W-1:0]            operand_b,
	input  logic signed [bmie_pkg::INVAL_W-1:0]    in_value,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [bmie_pkg::INDEX_W-1:0]           next_index,
	output logic signed [bmie_pkg::DATA_W-1:0]     out_value,
	output logic                                   out_valid,
	output logic                                   halted,
	output logic                                   div_fault
);

	bmie_pkg::bmie_cmd_t cmd;
	bmie_pkg::bmie_sts_t sts;

	// The controller only decides when to capture, divide and commit; all
	// instruction semantics live in the datapath.
	bmie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bmie_dpath #(
		.MEMORY_DEPTH (MEMORY_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.addr_a     (addr_a),
		.operand_b  (operand_b),
		.in_value   (in_value),
		.next_index (next_index),
		.out_value  (out_value),
		.out_valid  (out_valid),
		.halted     (halted),
		.div_fault  (div_fault)
	);

endmodule

@@ rtl/bmie_div.sv @@
// Bit-serial signed 8-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on bmie_pkg.
module bmie_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [bmie_pkg::DATA_W-1:0]      dividend,
	input  logic [bmie_pkg::DATA_W-1:0]      divisor,
	output logic [bmie_pkg::DATA_W-1:0]      quotient,
	output logic [bmie_pkg::DATA_W-1:0]      remainder,
	output logic                             busy
);

	localparam int W  = bmie_pkg::DATA_W;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic          qneg_q;
	logic          rneg_q;
	logic [W:0]    trial;
	logic          fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operands are held as magnitudes; the signs are reapplied at the output.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend[W-1] ? W'(-dividend) : dividend;
			dvs_q  <= divisor[W-1] ? W'(-divisor) : divisor;
			qneg_q <= dividend[W-1] ^ divisor[W-1];
			rneg_q <= dividend[W-1];
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quotient  = qneg_q ? W'(-quo_q) : quo_q;
	assign remainder = rneg_q ? W'(-rem_q) : rem_q;
	assign busy      = busy_q;

endmodule

@@ rtl/bmie_dpath.sv @@
// Datapath: data memory, operand registers, byte ALU, line index, halt flag, result registers.
// Depends on bmie_pkg and bmie_div.
module bmie_dpath #(
	parameter int MEMORY_DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bmie_pkg::bmie_cmd_t                    cmd,
	output bmie_pkg::bmie_sts_t                    sts,
	input  logic [bmie_pkg::ACTION_W-1:0]          action,
	input  logic [bmie_pkg::DATA_W-1:0]            addr_a,
	input  logic [bmie_pkg::DATA_W-1:0]            operand_b,
	input  logic signed [bmie_pkg::INVAL_W-1:0]    in_value,
	output logic [bmie_pkg::INDEX_W-1:0]           next_index,
	output logic signed [bmie_pkg::DATA_W-1:0]     out_value,
	output logic                                   out_valid,
	output logic                                   halted,
	output logic                                   div_fault
);

	localparam int W     = bmie_pkg::DATA_W;
	localparam int IW    = bmie_pkg::INDEX_W;
	localparam int AW    = $clog2(MEMORY_DEPTH);
	localparam int NADDR = 1 << W;

	logic [W-1:0]  mem [MEMORY_DEPTH];
	logic [AW-1:0] wrap_tbl [NADDR];

	logic [bmie_pkg::ACTION_W-1:0] op_q;
	logic [AW-1:0] wa_q;
	logic [W-1:0]  imm_q;
	logic [W-1:0]  inb_q;
	logic [W-1:0]  ua_q;
	logic [W-1:0]  ub_q;
	logic [IW-1:0] line_q;
	logic          halt_q;

	logic [W-1:0]  quo;
	logic [W-1:0]  rem;
	logic          div_busy;
	logic          b_zero;
	logic [2*W-1:0] prod;
	logic [2:0]    shr_cnt;
	logic [W-1:0]  wd;
	logic          we;
	logic [IW-1:0] nxt;
	logic          fault;
	logic          is_divmod;

	// Byte addresses wrap modulo the memory depth; the table is fixed at elaboration.
	for (genvar g = 0; g < NADDR; g++) begin : g_wrap
		assign wrap_tbl[g] = AW'(g % MEMORY_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa_q] <= wd;
		end
		if (cmd.capture) begin
			ua_q  <= mem[wrap_tbl[addr_a]];
			ub_q  <= mem[wrap_tbl[operand_b]];
			op_q  <= action;
			wa_q  <= wrap_tbl[addr_a];
			imm_q <= operand_b;
			inb_q <= in_value[W-1:0];
		end
	end

	bmie_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (ua_q),
		.divisor   (ub_q),
		.quotient  (quo),
		.remainder (rem),
		.busy      (div_busy)
	);

	assign b_zero    = ub_q == '0;
	assign is_divmod = op_q == bmie_pkg::OP_DIV || op_q == bmie_pkg::OP_MOD;
	assign prod      = (2*W)'(ua_q) * (2*W)'(ub_q);
	assign shr_cnt   = (ub_q >= W'(W)) ? 3'(W - 1) : ub_q[2:0];

	assign sts.div_needed = !halt_q && is_divmod && !b_zero;
	assign sts.div_busy   = div_busy;

	always_comb begin
		wd    = '0;
		we    = 1'b0;
		nxt   = line_q + IW'(1);
		fault = 1'b0;
		unique case (op_q)
			bmie_pkg::OP_COPY: begin
				wd = ub_q;  we = 1'b1;
			end
			bmie_pkg::OP_MOVE: begin
				wd = imm_q; we = 1'b1;
			end
			bmie_pkg::OP_ADD: begin
				wd = ua_q + ub_q; we = 1'b1;
			end
			bmie_pkg::OP_SUB: begin
				wd = ua_q - ub_q; we = 1'b1;
			end
			bmie_pkg::OP_MUL: begin
				wd = prod[W-1:0]; we = 1'b1;
			end
			bmie_pkg::OP_DIV: begin
				wd = b_zero ? '1 : quo; fault = b_zero; we = 1'b1;
			end
			bmie_pkg::OP_MOD: begin
				wd = b_zero ? ua_q : rem; fault = b_zero; we = 1'b1;
			end
			bmie_pkg::OP_AND: begin
				wd = ua_q & ub_q; we = 1'b1;
			end
			bmie_pkg::OP_OR: begin
				wd = ua_q | ub_q; we = 1'b1;
			end
			bmie_pkg::OP_NOT: begin
				wd = ~ua_q; we = 1'b1;
			end
			bmie_pkg::OP_XOR: begin
				wd = ua_q ^ ub_q; we = 1'b1;
			end
			bmie_pkg::OP_SHR: begin
				wd = W'($signed(ua_q) >>> shr_cnt); we = 1'b1;
			end
			bmie_pkg::OP_SHL: begin
				wd = (ub_q >= W'(W)) ? '0 : W'(ua_q << ub_q[2:0]); we = 1'b1;
			end
			bmie_pkg::OP_JUMP: begin
				nxt = {{(IW-W){1'b0}}, ua_q} + IW'(1);
			end
			bmie_pkg::OP_EQ: begin
				wd = W'($signed(ua_q) == $signed(ub_q)); we = 1'b1;
			end
			bmie_pkg::OP_GT: begin
				wd = W'($signed(ua_q) > $signed(ub_q)); we = 1'b1;
			end
			bmie_pkg::OP_LT: begin
				wd = W'($signed(ua_q) < $signed(ub_q)); we = 1'b1;
			end
			bmie_pkg::OP_SKIPIF: begin
				nxt = line_q + (ua_q[0] ? IW'(2) : IW'(3));
			end
			bmie_pkg::OP_HALT: begin
				nxt = line_q;
			end
			bmie_pkg::OP_IN: begin
				wd = inb_q; we = 1'b1;
			end
			default: begin
			end
		endcase
		// Once halted, nothing changes and the line stays where it is.
		if (halt_q) begin
			nxt   = line_q;
			fault = 1'b0;
		end
		we = we && cmd.commit && !halt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= IW'(1);
			halt_q <= 1'b0;
		end else if (cmd.commit) begin
			line_q <= nxt;
			if (op_q == bmie_pkg::OP_HALT) begin
				halt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_index <= nxt;
			out_valid  <= !halt_q && op_q == bmie_pkg::OP_OUT;
			out_value  <= (!halt_q && op_q == bmie_pkg::OP_OUT) ? ua_q : '0;
			halted     <= halt_q || op_q == bmie_pkg::OP_HALT;
			div_fault  <= fault;
		end
	end

endmodule

@@ rtl/bmie_ctrl.sv @@
// Controller state machine: sequences capture, divide and commit, and owns both handshakes.
// Depends on bmie_pkg.
module bmie_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                res_valid,
	input  logic                res_stall,
	input  bmie_pkg::bmie_sts_t sts,
	output bmie_pkg::bmie_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       res_valid_q;
	logic       out_free;

	assign in_stall = state_q != ST_IDLE;
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.div_needed) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy && out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

@@ rtl/bmie_chk.sv @@
// Port-level checker for the byte memory instruction executor, bound to the top level.
// Depends on bmie_pkg and byte_memory_instruction_executor_core.
module bmie_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_stall,
	input logic                                   res_valid,
	input logic                                   res_stall,
	input logic [bmie_pkg::INDEX_W-1:0]           next_index,
	input logic signed [bmie_pkg::DATA_W-1:0]     out_value,
	input logic                                   out_valid,
	input logic                                   halted,
	input logic                                   div_fault
);

	logic [1:0] inflight_q;
	logic       seen_halt_q;
	logic       in_xfer;
	logic       res_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign res_xfer = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			seen_halt_q <= 1'b0;
		end else begin
			if (in_xfer && !res_xfer) begin
				inflight_q <= inflight_q + 2'd1;
			end else if (!in_xfer && res_xfer) begin
				inflight_q <= inflight_q - 2'd1;
			end
			if (res_xfer && halted) begin
				seen_halt_q <= 1'b1;
			end
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(next_index) && $stable(out_value))
		else $error("result changed while stalled");

	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3 && (!res_valid || inflight_q != 2'd0))
		else $error("result count does not match accepted instructions");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_halt_q && res_valid |-> halted && !out_valid && !div_fault)
		else $error("activity after halt");

	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> !halted && !div_fault)
		else $error("output byte together with halt or fault");

endmodule

bind byte_memory_instruction_executor_core bmie_chk u_bmie_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.next_index (next_index),
	.out_value  (out_value),
	.out_valid  (out_valid),
	.halted     (halted),
	.div_fault  (div_fault)
);

@@ tb/sv/byte_memory_instruction_executor_core_test.sv @@
// Self-checking testbench for byte_memory_instruction_executor_core.
// Depends on bmie_pkg and the RTL of the block; holds stimulus, driver, monitor and the
// instruction predictor in one module.
module byte_memory_instruction_executor_core_test;

	import bmie_pkg::*;

	localparam int MEM_DEPTH = 256;
	localparam int RANDOM_INSTRS = 1500;

	// One decoded instruction as it is offered on the input channel. The wait_idle
	// mark is stimulus control only: the sender holds that instruction back until
	// every earlier instruction has returned its result.
	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic [DATA_W-1:0]         addr_a;
		logic [DATA_W-1:0]         operand_b;
		logic signed [INVAL_W-1:0] in_value;
		logic                      wait_idle;
	} instr_t;

	// What the block must return for one executed instruction.
	typedef struct packed {
		logic [INDEX_W-1:0]       next_index;
		logic signed [DATA_W-1:0] out_value;
		logic                     out_valid;
		logic                     halted;
		logic                     div_fault;
	} step_outcome_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [ACTION_W-1:0]       action = OP_NOP;
	logic [DATA_W-1:0]         addr_a = '0;
	logic [DATA_W-1:0]         operand_b = '0;
	logic signed [INVAL_W-1:0] in_value = '0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic [INDEX_W-1:0]        next_index;
	logic signed [DATA_W-1:0]  out_value;
	logic                      out_valid;
	logic                      halted;
	logic                      div_fault;

	// Instructions waiting to be offered, and results still owed by the block.
	instr_t        program_queue[$];
	step_outcome_t step_outcomes[$];

	// Mirror of the block's architectural state, advanced once per input transfer.
	logic signed [DATA_W-1:0] byte_mem [MEM_DEPTH];
	logic [INDEX_W-1:0]       line_now = 16'd1;
	logic                     halt_seen = 1'b0;

	// Addresses that the generated program has stored to. Reading any other entry
	// would return undefined data, so operand addresses are drawn from this list.
	bit                written [MEM_DEPTH];
	logic [DATA_W-1:0] known_addrs[$];

	// Idle pattern: phase 0 has a lazy sender and a very lazy receiver, phase 1
	// swaps the two, and phase 2 runs both sides flat out.
	logic [1:0] phase = 2'd0;
	int         issued = 0;
	int         issued_q = 0;
	int         in_flight = 0;
	int         hold_left = 0;
	int         holds_done = 0;
	int         mismatches = 0;

	logic [DATA_W-1:0] corner_bytes [10] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h07, 8'h08,
		8'h7F, 8'h80, 8'hFF, 8'hFE};

	byte_memory_instruction_executor_core #(
		.MEMORY_DEPTH(MEM_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.addr_a    (addr_a),
		.operand_b (operand_b),
		.in_value  (in_value),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.next_index(next_index),
		.out_value (out_value),
		.out_valid (out_valid),
		.halted    (halted),
		.div_fault (div_fault)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Executes one instruction on the mirrored state and returns the result the block
	// has to produce. All data arithmetic is on signed bytes truncated to 8 bits.
	function automatic step_outcome_t run_instruction(input instr_t it);
		step_outcome_t            o;
		logic signed [DATA_W-1:0] a_val;
		logic signed [DATA_W-1:0] b_val;
		logic signed [DATA_W-1:0] result;
		logic [DATA_W-1:0]        count;
		logic                     store;
		int                       a_idx;
		int                       b_idx;

		o.next_index = line_now + 16'd1;
		o.out_value = '0;
		o.out_valid = 1'b0;
		o.halted = 1'b0;
		o.div_fault = 1'b0;
		// Once halted, the block only repeats the frozen line index.
		if (halt_seen) begin
			o.next_index = line_now;
			o.halted = 1'b1;
			return o;
		end
		a_idx = int'(it.addr_a) % MEM_DEPTH;
		b_idx = int'(it.operand_b) % MEM_DEPTH;
		a_val = byte_mem[a_idx];
		b_val = byte_mem[b_idx];
		count = b_val;
		result = a_val;
		store = 1'b1;
		case (it.action)
			OP_COPY: result = b_val;
			OP_MOVE: result = it.operand_b;
			OP_ADD:  result = a_val + b_val;
			OP_SUB:  result = a_val - b_val;
			OP_MUL:  result = a_val * b_val;
			OP_DIV: begin
				// A zero divisor flags a fault and stores all ones. The -128 / -1
				// overflow wraps back to -128 through the truncation.
				if (b_val == 0) begin
					o.div_fault = 1'b1;
					result = -8'sd1;
				end else begin
					result = 8'(int'(a_val) / int'(b_val));
				end
			end
			OP_MOD: begin
				// A zero divisor flags a fault and leaves the dividend in place.
				if (b_val == 0) begin
					o.div_fault = 1'b1;
				end else begin
					result = 8'(int'(a_val) % int'(b_val));
				end
			end
			OP_AND:  result = a_val & b_val;
			OP_OR:   result = a_val | b_val;
			OP_NOT:  result = ~a_val;
			OP_XOR:  result = a_val ^ b_val;
			// Counts of 8 and above saturate: a full sign fill or zero.
			OP_SHR:  result = a_val >>> ((count >= 8) ? 8'd7 : count);
			OP_SHL:  result = (count >= 8) ? 8'sd0 : (a_val << count);
			OP_JUMP: begin
				store = 1'b0;
				o.next_index = {8'd0, a_val} + 16'd1;
			end
			OP_EQ:   result = (a_val == b_val) ? 8'sd1 : 8'sd0;
			OP_GT:   result = (a_val > b_val) ? 8'sd1 : 8'sd0;
			OP_LT:   result = (a_val < b_val) ? 8'sd1 : 8'sd0;
			OP_SKIPIF: begin
				store = 1'b0;
				o.next_index = line_now + (a_val[0] ? 16'd2 : 16'd3);
			end
			OP_HALT: begin
				store = 1'b0;
				halt_seen = 1'b1;
				o.next_index = line_now;
			end
			OP_OUT: begin
				store = 1'b0;
				o.out_value = a_val;
				o.out_valid = 1'b1;
			end
			OP_IN:   result = it.in_value[DATA_W-1:0];
			default: store = 1'b0;
		endcase
		if (store) begin
			byte_mem[a_idx] = result;
		end
		line_now = o.next_index;
		o.halted = halt_seen;
		return o;
	endfunction

	// Appends one instruction to the program and records the address it stores to.
	task automatic queue_instr(input logic [ACTION_W-1:0] op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic signed [INVAL_W-1:0] v,
			input logic wait_idle = 1'b0);
		instr_t it;

		it.action = op;
		it.addr_a = a;
		it.operand_b = b;
		it.in_value = v;
		it.wait_idle = wait_idle;
		program_queue.insert(program_queue.size(), it);
		if (op >= OP_COPY && op <= OP_IN && !(op inside {OP_JUMP, OP_SKIPIF, OP_HALT, OP_OUT})
				&& !written[a]) begin
			written[a] = 1'b1;
			known_addrs.insert(known_addrs.size(), a);
		end
	endtask

	function automatic logic [DATA_W-1:0] pick_known();
		return known_addrs[$urandom_range(known_addrs.size() - 1)];
	endfunction

	// A destination that is not read may be anywhere, fresh or already in use.
	function automatic logic [DATA_W-1:0] pick_dest();
		return $urandom_range(1) ? pick_known() : 8'($urandom_range(255));
	endfunction

	// Immediate bytes lean on the corners so that zero divisors, short shift counts
	// and sign extremes turn up often in the random part.
	function automatic logic [DATA_W-1:0] pick_byte();
		return $urandom_range(1) ? corner_bytes[$urandom_range(9)] : 8'($urandom_range(255));
	endfunction

	// Stimulus: build the whole program up front, then release reset.
	initial begin
		logic [ACTION_W-1:0] op;
		logic [DATA_W-1:0]   a;
		logic [DATA_W-1:0]   b;
		int                  r;

		// Directed part. Seed memory with the sign extremes, both address extremes
		// and an input truncation, then hit every operation but halt and the corners below.
		queue_instr(OP_MOVE, 8'd0, 8'h80, '0);
		queue_instr(OP_MOVE, 8'd255, 8'hFF, '0);
		queue_instr(OP_MOVE, 8'd1, 8'h00, '0);
		queue_instr(OP_MOVE, 8'd2, 8'h7F, '0);
		queue_instr(OP_IN, 8'd3, 8'h00, 16'sh7FFF);
		// Divide overflow: -128 / -1, then -128 mod -1 on the same byte.
		queue_instr(OP_COPY, 8'd5, 8'd0, '0);
		queue_instr(OP_DIV, 8'd5, 8'd255, '0);
		queue_instr(OP_MOD, 8'd5, 8'd255, '0);
		// Zero divisor for both divide and modulo.
		queue_instr(OP_DIV, 8'd2, 8'd1, '0);
		queue_instr(OP_MOD, 8'd0, 8'd1, '0);
		queue_instr(OP_ADD, 8'd3, 8'd0, '0);
		queue_instr(OP_SUB, 8'd1, 8'd0, '0);
		queue_instr(OP_MUL, 8'd255, 8'd0, '0);
		// Shift counts of 128 saturate: sign fill to the right, zero to the left.
		queue_instr(OP_SHR, 8'd0, 8'd255, '0);
		queue_instr(OP_SHL, 8'd3, 8'd255, '0);
		queue_instr(OP_NOT, 8'd1, 8'd0, '0);
		queue_instr(OP_XOR, 8'd1, 8'd0, '0);
		queue_instr(OP_AND, 8'd2, 8'd1, '0);
		queue_instr(OP_OR, 8'd2, 8'd3, '0);
		queue_instr(OP_EQ, 8'd5, 8'd255, '0);
		queue_instr(OP_GT, 8'd2, 8'd0, '0);
		queue_instr(OP_LT, 8'd3, 8'd0, '0);
		queue_instr(OP_SKIPIF, 8'd0, 8'd0, '0);
		queue_instr(OP_JUMP, 8'd2, 8'd0, '0);
		queue_instr(OP_OUT, 8'd5, 8'd0, '0);
		queue_instr(OP_NOP, 8'd0, 8'd0, -16'sd32768);
		queue_instr(5'd31, 8'd255, 8'd255, 16'sh7FFF);

		// Random part. Every operand that is read comes from a stored address; one
		// instruction in the middle waits until the block has drained completely.
		for (int n = 0; n < RANDOM_INSTRS; n++) begin
			r = $urandom_range(99);
			if (r < 22) begin
				queue_instr(OP_MOVE, pick_dest(), pick_byte(), 16'($urandom), n == 700);
			end else if (r < 27) begin
				queue_instr(OP_IN, pick_dest(), 8'($urandom), 16'($urandom), n == 700);
			end else if (r < 30) begin
				op = (r < 28) ? OP_NOP : 5'($urandom_range(31, 22));
				queue_instr(op, 8'($urandom), 8'($urandom), 16'($urandom), n == 700);
			end else begin
				op = 5'($urandom_range(OP_OUT, OP_COPY));
				// Halt is kept for the very end; the move slot goes to divide and
				// the halt slot to modulo so both see more traffic.
				if (op == OP_MOVE) begin
					op = OP_DIV;
				end else if (op == OP_HALT) begin
					op = OP_MOD;
				end
				a = (op inside {[OP_ADD:OP_SKIPIF], OP_OUT}) ? pick_known() : pick_dest();
				b = (op inside {OP_COPY, [OP_ADD:OP_OR], [OP_XOR:OP_SHL], [OP_EQ:OP_LT]})
					? pick_known() : 8'($urandom);
				queue_instr(op, a, b, 16'($urandom), n == 700);
			end
		end

		// Halt after a full drain, then a few instructions that must all be ignored.
		queue_instr(OP_HALT, pick_known(), 8'($urandom), 16'($urandom), 1'b1);
		queue_instr(OP_OUT, pick_known(), 8'd0, '0);
		queue_instr(OP_DIV, pick_known(), pick_known(), '0);
		queue_instr(OP_MOVE, pick_known(), 8'h5A, '0);
		queue_instr(OP_JUMP, pick_known(), 8'd0, '0);
		queue_instr(5'd22, pick_known(), 8'd0, '0);
		queue_instr(OP_IN, pick_known(), 8'd0, 16'sh1234);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until the program is offered and accepted, then until every result
		// is back, then a little longer to catch any stray result transfer.
		while (program_queue.size() != 0 || in_valid) @(posedge clk);
		while (step_outcomes.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Sender. A new instruction is presented only when the channel is empty or the
	// current one has just been transferred; a stalled instruction is held as is.
	always @(posedge clk or negedge arst_n) begin : sender
		instr_t it;
		logic   offer;

		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= OP_NOP;
			addr_a <= '0;
			operand_b <= '0;
			in_value <= '0;
			in_flight = 0;
		end else begin
			// Count instructions inside the block from this side of the clock edge
			// so that the drain check needs nothing from the monitor.
			if (in_valid && !in_stall) begin
				in_flight++;
			end
			if (res_valid && !res_stall) begin
				in_flight--;
			end
			if (!in_valid || !in_stall) begin
				offer = program_queue.size() != 0;
				if (offer && program_queue[0].wait_idle && in_flight != 0) begin
					offer = 1'b0;
				end
				if (offer && phase == 2'd0 && $urandom_range(99) < 17) begin
					offer = 1'b0;
				end
				if (offer && phase == 2'd1 && $urandom_range(99) < 84) begin
					offer = 1'b0;
				end
				if (offer) begin
					it = program_queue.pop_front();
					action <= it.action;
					addr_a <= it.addr_a;
					operand_b <= it.operand_b;
					in_value <= it.in_value;
					in_valid <= 1'b1;
					issued++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			issued_q <= issued;
			phase <= (issued < 600) ? 2'd0 : (issued < 1150) ? 2'd1 : 2'd2;
		end
	end

	// Receiver. Besides the random stalls of each phase it holds off twice for a
	// long stretch while the sender keeps offering, so the block fills up and has
	// to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if ((holds_done == 0 && issued_q >= 300) || (holds_done == 1 && issued_q >= 1300)) begin
				hold_left = 60;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				case (phase)
					2'd0:    res_stall <= $urandom_range(99) < 84;
					2'd1:    res_stall <= $urandom_range(99) < 17;
					default: res_stall <= 1'b0;
				endcase
			end
		end
	end

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%h got 0x%h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Monitor. Every result transfer is checked against the oldest prediction, and
	// every input transfer is run through the predictor in acceptance order.
	always @(posedge clk) begin : monitor
		step_outcome_t want;
		instr_t        seen;

		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (step_outcomes.size() == 0) begin
					$display("%0t: result transfer with no instruction outstanding, next_index 0x%h",
						$time, next_index);
					mismatches++;
				end else begin
					want = step_outcomes.pop_front();
					compare_field("next_index", want.next_index, next_index);
					compare_field("out_value", 16'(want.out_value), 16'(out_value));
					compare_field("out_valid", 16'(want.out_valid), 16'(out_valid));
					compare_field("halted", 16'(want.halted), 16'(halted));
					compare_field("div_fault", 16'(want.div_fault), 16'(div_fault));
				end
			end
			if (in_valid && !in_stall) begin
				seen.action = action;
				seen.addr_a = addr_a;
				seen.operand_b = operand_b;
				seen.in_value = in_value;
				seen.wait_idle = 1'b0;
				step_outcomes.insert(step_outcomes.size(), run_instruction(seen));
			end
		end
	end

endmodule

@@ files.f @@
rtl/bmie_pkg.sv
rtl/bmie_div.sv
rtl/bmie_dpath.sv
rtl/bmie_ctrl.sv
rtl/byte_memory_instruction_executor_core.sv
rtl/bmie_chk.sv
tb/sv/byte_memory_instruction_executor_core_test.sv
